/* rtl/core/sid_pkg.sv */
`timescale 1ns / 1ps

package sid_pkg;

   localparam int NUM_W   = 64;   // width of the input number port
   localparam int CAP_W   = 7;    // width of the capacity register
   localparam int LEN_W   = 5;    // width of the text length field
   localparam int CHAR_W  = 8;    // width of one ASCII character

   localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd32;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

/* rtl/core/sid_dabble.sv */
`timescale 1ns / 1ps

// One shift-add-3 step: correct every BCD digit, then shift in one binary bit.
module sid_dabble #(
   parameter int DIGITS = 19
) (
   input  logic [4*DIGITS-1:0] bcd_cur,
   input  logic                shift_bit,
   output logic [4*DIGITS-1:0] bcd_next
);

   logic [4*DIGITS-1:0] bcd_adj;

   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_cur[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_cur[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_cur[4*d +: 4];
         end
      end
   end

   assign bcd_next = {bcd_adj[4*DIGITS-2:0], shift_bit};

endmodule

/* rtl/core/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps

// Signed integer to decimal ASCII text. Each accepted req beat carries one two's
// complement number (low VALUE_BITS bits used, bit VALUE_BITS-1 is the sign); the
// block answers with one rsp beat per character, most significant first: a '-'
// for negative values, then the digits without leading zeros ("0" for zero), the
// final beat flagged by rsp_last_char and every beat carrying the total length.
// If the length is not below the capacity register (csr_write_data, reset 32),
// a single beat with rsp_fitted low, length 0 and character 0 is sent instead.
// Timing: one item at a time; req_stall is high from acceptance until the last
// character has been loaded into the output register. A conversion shifts the
// magnitude through the single shift-add-3 step unit (one input bit per cycle),
// then scans off the leading zero digits, then emits the characters, holding
// each one in the output register while rsp is stalled.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 64
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_write_enable,
   input  logic [sid_pkg::CAP_W-1:0]    csr_write_data,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [sid_pkg::NUM_W-1:0] req_number_in,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sid_pkg::CHAR_W-1:0]   rsp_text_char,
   output logic                         rsp_last_char,
   output logic [sid_pkg::LEN_W-1:0]    rsp_text_length,
   output logic                         rsp_fitted
);

   // decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
   localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_W  = 4 * DIGITS;
   localparam int CNT_W  = $clog2(VALUE_BITS + 1);
   localparam int DIG_W  = $clog2(DIGITS + 1);

   sid_pkg::state_type state_ff, state_in;

   logic [sid_pkg::CAP_W-1:0]  cap_ff;
   logic [VALUE_BITS-1:0]      mag_ff, mag_in;
   logic [BCD_W-1:0]           bcd_ff, bcd_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [DIG_W-1:0]           ndig_ff, ndig_in;
   logic                       neg_ff, neg_in;
   logic                       fit_ff, fit_in;
   logic [sid_pkg::LEN_W-1:0]  len_ff, len_in;

   logic                       out_valid_ff, out_valid_in;
   logic [sid_pkg::CHAR_W-1:0] out_char_ff, out_char_in;
   logic                       out_last_ff, out_last_in;
   logic [sid_pkg::LEN_W-1:0]  out_len_ff, out_len_in;
   logic                       out_fit_ff, out_fit_in;

   logic [VALUE_BITS-1:0]      x_raw;
   logic [BCD_W-1:0]           bcd_step;
   logic [3:0]                 top_digit;
   logic [sid_pkg::LEN_W-1:0]  len_calc;
   logic                       out_free;
   logic                       req_accept;

   sid_dabble #(.DIGITS(DIGITS)) u_dabble (
      .bcd_cur   (bcd_ff),
      .shift_bit (mag_ff[VALUE_BITS-1]),
      .bcd_next  (bcd_step)
   );

   assign x_raw      = req_number_in[VALUE_BITS-1:0];
   assign top_digit  = bcd_ff[BCD_W-1 -: 4];
   assign len_calc   = sid_pkg::LEN_W'(ndig_ff) + sid_pkg::LEN_W'(neg_ff);
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != sid_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // next state, sequencer data path and output register
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      count_in     = count_ff;
      ndig_in      = ndig_ff;
      neg_in       = neg_ff;
      fit_in       = fit_ff;
      len_in       = len_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_len_in   = out_len_ff;
      out_fit_in   = out_fit_ff;

      case (state_ff)
         sid_pkg::ST_IDLE: begin
            if (req_accept) begin
               // take the magnitude as unsigned so the most negative value survives
               neg_in   = x_raw[VALUE_BITS-1];
               mag_in   = x_raw[VALUE_BITS-1] ? (VALUE_BITS'(0) - x_raw) : x_raw;
               bcd_in   = '0;
               count_in = CNT_W'(VALUE_BITS);
               state_in = sid_pkg::ST_CONVERT;
            end
         end
         sid_pkg::ST_CONVERT: begin
            // one binary bit into the BCD register per cycle
            bcd_in   = bcd_step;
            mag_in   = {mag_ff[VALUE_BITS-2:0], 1'b0};
            count_in = count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               ndig_in  = DIG_W'(DIGITS);
               state_in = sid_pkg::ST_SCAN;
            end
         end
         sid_pkg::ST_SCAN: begin
            // drop leading zeros, keeping at least one digit
            if (top_digit == 4'd0 && ndig_ff > DIG_W'(1)) begin
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
               ndig_in = ndig_ff - 1'b1;
            end else begin
               len_in   = len_calc;
               fit_in   = ({{(sid_pkg::CAP_W-sid_pkg::LEN_W){1'b0}}, len_calc} < cap_ff);
               state_in = sid_pkg::ST_EMIT;
            end
         end
         sid_pkg::ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (!fit_ff) begin
                  out_char_in = sid_pkg::CHAR_NONE;
                  out_last_in = 1'b1;
                  out_len_in  = '0;
                  out_fit_in  = 1'b0;
                  state_in    = sid_pkg::ST_IDLE;
               end else if (neg_ff) begin
                  out_char_in = sid_pkg::CHAR_MINUS;
                  out_last_in = 1'b0;
                  out_len_in  = len_ff;
                  out_fit_in  = 1'b1;
                  neg_in      = 1'b0;
               end else begin
                  out_char_in = sid_pkg::CHAR_ZERO | {4'd0, top_digit};
                  out_last_in = (ndig_ff == DIG_W'(1));
                  out_len_in  = len_ff;
                  out_fit_in  = 1'b1;
                  bcd_in      = {bcd_ff[BCD_W-5:0], 4'd0};
                  ndig_in     = ndig_ff - 1'b1;
                  if (ndig_ff == DIG_W'(1)) begin
                     state_in = sid_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = sid_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sid_pkg::ST_IDLE;
         cap_ff       <= sid_pkg::CAP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      count_ff    <= count_in;
      ndig_ff     <= ndig_in;
      neg_ff      <= neg_in;
      fit_ff      <= fit_in;
      len_ff      <= len_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_len_ff  <= out_len_in;
      out_fit_ff  <= out_fit_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_text_char   = out_char_ff;
   assign rsp_last_char   = out_last_ff;
   assign rsp_text_length = out_len_ff;
   assign rsp_fitted      = out_fit_ff;

`ifndef SYNTH
   // a not-fitted beat is always the lone, last beat with no length
   a_unfit_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fitted) |-> (rsp_last_char && rsp_text_length == '0 &&
                                      rsp_text_char == sid_pkg::CHAR_NONE))
      else $error("not-fitted beat malformed");

   // a fitted beat respects the capacity; user sets it while idle, not enforced
   a_fit_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fitted) |->
         (rsp_text_length != '0 &&
          {{(sid_pkg::CAP_W-sid_pkg::LEN_W){1'b0}}, rsp_text_length} < cap_ff))
      else $error("fitted beat exceeds capacity");

   // while emitting digits, at least one digit remains
   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sid_pkg::ST_EMIT && fit_ff && !neg_ff) |-> (ndig_ff != '0))
      else $error("digit counter underflow");

   // an accepted item starts the conversion
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == sid_pkg::ST_CONVERT))
      else $error("accepted item did not start conversion");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int VALUE_BITS     = 64;
   localparam int RANDOM_PHASES  = 10;
   localparam int ITEMS_PER_PHASE = 12;
   localparam int SETTLE_CYCLES  = 8;     // idle margin before a capacity write
   localparam int TAIL_CYCLES    = 200;   // margin after the last expected beat
   localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake

   // one character beat as it leaves the block
   typedef struct packed {
      logic [sid_pkg::CHAR_W-1:0] text_char;
      logic                       last_char;
      logic [sid_pkg::LEN_W-1:0]  text_length;
      logic                       fitted;
   } char_beat_type;

   // Predicts the decimal text of every accepted number and checks the
   // character beats against it in order.
   class decimal_text_checker;
      char_beat_type             expected_chars[$];
      logic [sid_pkg::CAP_W-1:0] capacity = sid_pkg::CAP_RESET;
      int                        errors = 0;
      int                        numbers_seen = 0;
      int                        beats_checked = 0;
      int                        not_fitted_count = 0;

      function void note_number(logic [sid_pkg::NUM_W-1:0] raw);
         logic [sid_pkg::NUM_W-1:0]  mask;
         logic [sid_pkg::NUM_W-1:0]  value;
         logic [sid_pkg::NUM_W-1:0]  mag;
         logic [sid_pkg::NUM_W-1:0]  rem;
         logic                       negative;
         logic [sid_pkg::CHAR_W-1:0] digit_rev [0:19];
         logic [sid_pkg::LEN_W-1:0]  text_len;
         char_beat_type              beat;
         int                         ndig;
         mask     = {sid_pkg::NUM_W{1'b1}} >> (sid_pkg::NUM_W - VALUE_BITS);
         value    = raw & mask;
         negative = value[VALUE_BITS-1];
         mag      = negative ? ((0 - value) & mask) : value;
         ndig     = 0;
         // peel digits off the unsigned magnitude, least significant first
         do begin
            rem = mag % 10;
            if (ndig < 20) begin
               digit_rev[ndig] = sid_pkg::CHAR_ZERO + rem[sid_pkg::CHAR_W-1:0];
               ndig++;
            end
            mag = mag / 10;
         end while (mag != 0);
         text_len = sid_pkg::LEN_W'(ndig + (negative ? 1 : 0));
         numbers_seen++;
         if ({2'b00, text_len} >= capacity) begin
            beat.text_char   = sid_pkg::CHAR_NONE;
            beat.last_char   = 1'b1;
            beat.text_length = '0;
            beat.fitted      = 1'b0;
            expected_chars.push_back(beat);
            not_fitted_count++;
            return;
         end
         beat.text_length = text_len;
         beat.fitted      = 1'b1;
         if (negative) begin
            beat.text_char = sid_pkg::CHAR_MINUS;
            beat.last_char = 1'b0;
            expected_chars.push_back(beat);
         end
         for (int i = ndig - 1; i >= 0; i--) begin
            beat.text_char = digit_rev[i];
            beat.last_char = (i == 0);
            expected_chars.push_back(beat);
         end
      endfunction

      function void check_char(char_beat_type got);
         char_beat_type want;
         beats_checked++;
         if (expected_chars.size() == 0) begin
            $error("unexpected character beat: char %h last %b len %0d fitted %b",
                   got.text_char, got.last_char, got.text_length, got.fitted);
            errors++;
            return;
         end
         want = expected_chars.pop_front();
         if (got.text_char !== want.text_char) begin
            $error("text_char: expected %h, got %h", want.text_char, got.text_char);
            errors++;
         end
         if (got.last_char !== want.last_char) begin
            $error("last_char: expected %b, got %b", want.last_char, got.last_char);
            errors++;
         end
         if (got.text_length !== want.text_length) begin
            $error("text_length: expected %0d, got %0d", want.text_length,
                   got.text_length);
            errors++;
         end
         if (got.fitted !== want.fitted) begin
            $error("fitted: expected %b, got %b", want.fitted, got.fitted);
            errors++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [sid_pkg::CAP_W-1:0]         csr_write_data;
   logic                              req_valid;
   logic                              req_stall;
   logic signed [sid_pkg::NUM_W-1:0]  req_number_in;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [sid_pkg::CHAR_W-1:0]        rsp_text_char;
   logic                              rsp_last_char;
   logic [sid_pkg::LEN_W-1:0]         rsp_text_length;
   logic                              rsp_fitted;

   decimal_text_checker text_checker;
   int                  capacity_writes = 0;
   int                  idle_cycles = 0;

   signed_int_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_number_in   (req_number_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char),
      .rsp_text_length (rsp_text_length),
      .rsp_fitted      (rsp_fitted)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 99) < 10) begin
         return $urandom_range(15, 60);
      end
      return $urandom_range(0, 3);
   endfunction

   // Pick a number: full-width noise, random magnitudes, values around powers
   // of ten (where the digit count changes), small values and the extremes.
   function automatic logic [sid_pkg::NUM_W-1:0] random_number();
      logic [sid_pkg::NUM_W-1:0] full;
      logic [sid_pkg::NUM_W-1:0] pow10;
      logic [sid_pkg::NUM_W-1:0] value;
      int                        pick;
      int                        nbits;
      full  = {$urandom, $urandom};
      pick  = $urandom_range(0, 9);
      pow10 = 1;
      case (pick)
         0, 1, 2: begin
            value = full;
         end
         3, 4, 5: begin
            nbits = $urandom_range(1, sid_pkg::NUM_W);
            value = full >> (sid_pkg::NUM_W - nbits);
            if ($urandom_range(0, 1)) value = 0 - value;
         end
         6, 7: begin
            repeat ($urandom_range(0, 19)) pow10 = pow10 * 10;
            value = pow10 + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) value = 0 - value;
         end
         8: begin
            value = $urandom_range(0, 40) - 20;
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       value = {1'b1, {(sid_pkg::NUM_W-1){1'b0}}};
               1:       value = {1'b0, {(sid_pkg::NUM_W-1){1'b1}}};
               2:       value = {1'b1, {(sid_pkg::NUM_W-2){1'b0}}, 1'b1};
               3:       value = {1'b0, {(sid_pkg::NUM_W-2){1'b1}}, 1'b0};
               default: value = '0;
            endcase
         end
      endcase
      return value;
   endfunction

   // Present one number and hold it until the block takes it.
   task automatic send_number(logic [sid_pkg::NUM_W-1:0] number);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_number_in <= number;
      do @(posedge clock); while (req_stall);
      text_checker.note_number(number);
   endtask

   // Drop valid for a given number of cycles before the next beat.
   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Drop valid, wait for every outstanding character, then let the block settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (text_checker.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only call with the block idle.
   task automatic write_capacity(logic [sid_pkg::CAP_W-1:0] cap);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      text_checker.capacity = cap;
      capacity_writes++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver back-pressure: stretches of free flow alternate with stalls,
   // sometimes long free runs so bursts go through untouched.
   initial begin
      int free_run;
      int stall_run;
      rsp_stall <= 1'b0;
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            free_run = $urandom_range(20, 80);
         end else begin
            free_run = $urandom_range(1, 4);
         end
         stall_run = gap_length();
         repeat (free_run) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (stall_run) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Check every character beat the block hands over.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         text_checker.check_char({rsp_text_char, rsp_last_char, rsp_text_length,
                                  rsp_fitted});
      end
   end

   // Hang detector: count cycles where no handshake of any kind happens.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || csr_write_enable) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [sid_pkg::NUM_W-1:0] directed [$];
      logic [sid_pkg::CAP_W-1:0] phase_cap;
      bit                        no_gaps;
      text_checker      = new;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_number_in    <= '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity: zero, single digits, digit-count
      // boundaries, both signs, the most negative value and bit patterns.
      directed = '{64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10,
                   64'd99, 64'd100, 64'd12345, -64'sd12345,
                   64'd1000000000000000000, 64'd999999999999999999,
                   -64'sd1000000000000000000,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555,
                   64'hAAAA_AAAA_AAAA_AAAA};
      foreach (directed[i]) begin
         send_number(directed[i]);
      end

      // Capacity edges: nothing fits at 0 or 1, two characters just miss at 2,
      // the 20-character minimum fits only from 21 up.
      write_capacity(7'd0);
      send_number(64'd0);
      write_capacity(7'd1);
      send_number(64'd5);
      write_capacity(7'd2);
      send_number(64'd7);
      send_number(-64'sd7);
      write_capacity(7'd20);
      send_number(64'h8000_0000_0000_0000);
      send_number(64'h7FFF_FFFF_FFFF_FFFF);
      write_capacity(7'd21);
      send_number(64'h8000_0000_0000_0000);

      // Random phases, each under its own capacity.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       phase_cap = 7'd127;
            1:       phase_cap = 7'd0;
            2:       phase_cap = 7'd64;
            3:       phase_cap = 7'd1;
            default: phase_cap = $urandom_range(2, 22);
         endcase
         write_capacity(phase_cap);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_number(random_number());
            if ($urandom_range(0, 19) == 0) begin
               // hold off until the block has handed over every character
               drain();
            end else if (!no_gaps) begin
               pause_sender(gap_length());
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (text_checker.expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d numbers into %0d character beats; %0d did not fit.",
               text_checker.numbers_seen, text_checker.beats_checked,
               text_checker.not_fitted_count);
      $display("Capacity was rewritten %0d times, from 0 up to 127.", capacity_writes);
      if (text_checker.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
